>>> rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int WIDTH = 32;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4
  } kind_t;

  localparam logic [1:0] ORDER_LESS    = 2'd0;
  localparam logic [1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [1:0] ORDER_GREATER = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic [1:0]         order;
    logic [1:0]         status;
  } out_item_t;

  // request and reply between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_sts_t;

endpackage
`default_nettype wire

>>> rtl/rational_arithmetic_unit_top.sv
`default_nettype none
// Compare runs two product steps and a combine step before the result; each
// reduction runs one divider pass per Euclid step plus the two final
// divisions; divide runs two reductions.
// Throughput: one item at a time; the shared 1-bit-per-cycle divider sets the
// figure, and a waiting result does not hold off the next input transfer.
// Reset: synchronous, returns the sequencer to idle and drops the result.
module rational_arithmetic_unit_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rau_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rau_pkg::out_item_t      out_data
);
  import rau_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_MUL   = 11'b00000000010,
    ST_COMB  = 11'b00000000100,
    ST_RED   = 11'b00000001000,
    ST_EUC   = 11'b00000010000,
    ST_EUCW  = 11'b00000100000,
    ST_QN    = 11'b00001000000,
    ST_QNW   = 11'b00010000000,
    ST_QD    = 11'b00100000000,
    ST_QDW   = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  state_t state;
  logic [2:0] kind;
  logic signed [WIDTH-1:0] an, ad, bn, bd;
  logic signed [WIDTH-1:0] num, den, ex, ey, gcd;
  logic signed [WIDTH-1:0] p1, p2;
  logic [1:0] step;
  logic       second;
  logic       zz, ov;
  out_item_t  res;

  // shared multiplier
  logic signed [WIDTH-1:0]   mx, my;
  logic signed [2*WIDTH-1:0] mp;
  logic signed [WIDTH-1:0]   mw;
  logic                      mov;
  assign mp  = mx * my;
  assign mw  = mp[WIDTH-1:0];
  assign mov = mp != {{WIDTH{mw[WIDTH-1]}}, mw};

  always_comb begin
    mx = an;
    my = bd;
    case (step)
      2'd0: begin
        mx = (kind == KIND_MUL || kind == KIND_DIV) ? an : an;
        my = (kind == KIND_MUL || kind == KIND_DIV) ? bn : bd;
      end
      2'd1: begin
        mx = bn;
        my = ad;
      end
      2'd2: begin
        mx = ad;
        my = bd;
      end
      default: begin
        mx = an;
        my = bd;
      end
    endcase
  end

  // shared divider
  div_ctl_t dctl;
  div_sts_t dsts;
  logic signed [WIDTH-1:0] dvd, dvs, dq, dr;
  rau_div u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(dvd), .divisor(dvs),
    .sts(dsts), .quot(dq), .rem(dr)
  );

  assign dctl.start = (state == ST_EUC) || (state == ST_QN) || (state == ST_QD);
  always_comb begin
    case (state)
      ST_EUC:  begin dvd = ey;  dvs = ex;  end
      ST_QN:   begin dvd = num; dvs = gcd; end
      default: begin dvd = den; dvs = gcd; end
    endcase
  end

  logic signed [WIDTH:0] sum;
  assign sum = (kind == KIND_ADD) ? ({p1[WIDTH-1], p1} + {p2[WIDTH-1], p2})
                                  : ({p1[WIDTH-1], p1} - {p2[WIDTH-1], p2});

  // quotient wraps only for minimum value over -1
  logic qwrap;
  assign qwrap = (dvd == {1'b1, {(WIDTH-1){1'b0}}}) && (dvs == '1);

  assign in_ready = (state == ST_IDLE);

  // sequence one item through products and, for all but compare, the Euclid loop and final divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            kind   <= in_data.kind;
            an     <= in_data.a_num;
            ad     <= in_data.a_den;
            bn     <= in_data.b_num;
            bd     <= in_data.b_den;
            zz     <= 1'b0;
            ov     <= 1'b0;
            second <= 1'b0;
            step   <= 2'd0;
            res    <= '0;
            if (in_data.kind == KIND_DIV) begin
              num   <= in_data.b_den;
              den   <= in_data.b_num;
              ex    <= in_data.b_den;
              ey    <= in_data.b_num;
              state <= ST_RED;
            end else if (in_data.kind > KIND_CMP) begin
              state <= ST_OUT;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mov) ov <= 1'b1;
          case (step)
            2'd0: begin
              if (kind == KIND_MUL || kind == KIND_DIV) begin
                num  <= mw;
                step <= 2'd2;
              end else begin
                p1   <= mw;
                step <= 2'd1;
              end
            end
            2'd1: begin
              p2   <= mw;
              step <= 2'd2;
              if (kind == KIND_CMP) state <= ST_COMB;
            end
            default: begin
              den <= mw;
              ex  <= num;
              ey  <= mw;
              state <= (kind == KIND_MUL || kind == KIND_DIV) ? ST_RED : ST_COMB;
            end
          endcase
        end
        ST_COMB: begin
          if (kind == KIND_CMP) begin
            res.order <= (p1 < p2) ? ORDER_LESS :
                         (p1 == p2) ? ORDER_EQUAL : ORDER_GREATER;
            state <= ST_OUT;
          end else begin
            num <= sum[WIDTH-1:0];
            ex  <= sum[WIDTH-1:0];
            ey  <= den;
            if (sum[WIDTH] != sum[WIDTH-1]) ov <= 1'b1;
            state <= ST_RED;
          end
        end
        ST_RED: begin
          if (ex == '0) begin
            gcd <= ey;
            if (ey == '0) begin
              zz <= 1'b1;
              res.res_num <= '0;
              res.res_den <= '0;
              num <= '0;
              den <= '0;
              state <= ST_QDW;
            end else state <= ST_QN;
          end else state <= ST_EUC;
        end
        ST_EUC: state <= ST_EUCW;
        ST_EUCW: begin
          if (dsts.done) begin
            ey <= ex;
            ex <= (ex == '1) ? '0 : dr;
            state <= ST_RED;
          end
        end
        ST_QN: begin
          if (qwrap) ov <= 1'b1;
          state <= ST_QNW;
        end
        ST_QNW: if (dsts.done) begin
          num <= dq;
          state <= ST_QD;
        end
        ST_QD: begin
          if (qwrap) ov <= 1'b1;
          state <= ST_QDW;
        end
        ST_QDW: begin
          if (dsts.done || zz) begin
            if (!zz) den <= dq;
            if (kind == KIND_DIV && !second) begin
              second <= 1'b1;
              // reciprocal is in num/dq; multiply a by it
              bn   <= zz ? '0 : num;
              bd   <= zz ? '0 : dq;
              step <= 2'd0;
              state <= ST_MUL;
            end else begin
              res.res_num <= zz ? '0 : num;
              res.res_den <= zz ? '0 : dq;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid) begin
            out_data.res_num <= res.res_num;
            out_data.res_den <= res.res_den;
            out_data.order   <= res.order;
            out_data.status  <= zz ? STATUS_ZERO : (ov ? STATUS_OVERFLOW : STATUS_OK);
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    dctl.start |-> !dsts.busy) else $error("divider restarted while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT)) else $error("spurious result");
`endif

endmodule
`default_nettype wire

>>> rtl/rau_div.sv
`default_nettype none
// Signed truncating divider, one quotient bit per cycle (restoring).
module rau_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rau_pkg::div_ctl_t               ctl,
  input  wire logic signed [rau_pkg::WIDTH-1:0] dividend,
  input  wire logic signed [rau_pkg::WIDTH-1:0] divisor,
  output rau_pkg::div_sts_t                    sts,
  output logic signed [rau_pkg::WIDTH-1:0]     quot,
  output logic signed [rau_pkg::WIDTH-1:0]     rem
);
  import rau_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] q;
  logic [WIDTH:0]   r;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             neg_q;
  logic             neg_r;
  logic             done;
  logic [WIDTH:0]   r_shift;
  logic [WIDTH:0]   r_sub;

  assign r_shift = {r[WIDTH-1:0], q[WIDTH-1]};
  assign r_sub   = r_shift - {1'b0, dvs};

  // run one restoring step per cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy  <= 1'b1;
        cnt   <= CW'(WIDTH);
        q     <= dividend[WIDTH-1] ? WIDTH'(-dividend) : dividend;
        dvs   <= divisor[WIDTH-1] ? WIDTH'(-divisor) : divisor;
        r     <= '0;
        neg_q <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
        neg_r <= dividend[WIDTH-1];
      end else if (busy) begin
        if (r_sub[WIDTH]) begin
          r <= r_shift;
          q <= {q[WIDTH-2:0], 1'b0};
        end else begin
          r <= r_sub;
          q <= {q[WIDTH-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot     = neg_q ? WIDTH'(-q) : q;
  assign rem      = neg_r ? WIDTH'(-r[WIDTH-1:0]) : r[WIDTH-1:0];
  assign sts.done = done;
  assign sts.busy = busy;

endmodule
`default_nettype wire
